@@ rtl/core/upf_pkg.sv @@
// Package for the UTF-8 punctuation fold block: codes, result and state types,
// the fold table and the saturating counter step. No dependencies.
`timescale 1ns / 1ps

package upf_pkg;

   // Width of the internal fold counter; the result field is its low 24 bits.
   localparam int COUNT_BITS = 24;
   localparam int FIELD_BITS = 24;

   // Prefix tracking codes.
   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_E2    = 2'd1;
   localparam logic [1:0] PHASE_E2_80 = 2'd2;

   // Line end modes.
   localparam logic [1:0] MODE_CR   = 2'd0;
   localparam logic [1:0] MODE_LF   = 2'd1;
   localparam logic [1:0] MODE_CRLF = 2'd2;

   // Byte values the logic looks for or emits.
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_LEAD_E2 = 8'hE2;
   localparam logic [7:0] BYTE_SEC_80  = 8'h80;
   localparam logic [7:0] BYTE_LEAD_LO = 8'hC0;
   localparam logic [7:0] BYTE_QMARK   = 8'h3F;

   typedef struct packed {
      logic                  byte_valid;
      logic [7:0]            out_byte;
      logic                  last_of_text;
      logic [FIELD_BITS-1:0] fold_count;
   } upf_result_type;

   typedef struct packed {
      logic [1:0]            phase;
      logic                  drop_lf;
      logic                  skip;
      logic [COUNT_BITS-1:0] count;
   } upf_state_type;

   // One push into the result queue: how many results and the results.
   typedef struct packed {
      logic           push;
      logic [1:0]     n_res;
      upf_result_type r0;
      upf_result_type r1;
   } upf_push_type;

   // Third byte of an E2 80 sequence to its 8-bit code; bit 8 flags a match.
   function automatic logic [8:0] fold_code(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h98:   r = {1'b1, 8'hD4};
         8'h99:   r = {1'b1, 8'hD5};
         8'h9C:   r = {1'b1, 8'hD2};
         8'h9D:   r = {1'b1, 8'hD3};
         8'h93:   r = {1'b1, 8'hD0};
         8'h94:   r = {1'b1, 8'hD1};
         8'hA6:   r = {1'b1, 8'hC9};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Counter step that stops at all ones.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      r = (c == {COUNT_BITS{1'b1}}) ? c : c + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      return r;
   endfunction

   // Low bits of the counter as the result field.
   function automatic logic [FIELD_BITS-1:0] count_field(input logic [COUNT_BITS-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

@@ rtl/core/upf_fold_logic.sv @@
// Combinational next-state and result logic for one byte of the fold block.
// Depends on upf_pkg for codes, types and the fold table.
`timescale 1ns / 1ps

module upf_fold_logic (
   input  logic [7:0]            in_byte,
   input  logic                  end_of_text,
   input  logic [1:0]            line_end_mode,
   input  upf_pkg::upf_state_type state_cur,
   output upf_pkg::upf_state_type state_nxt,
   output upf_pkg::upf_result_type r0,
   output upf_pkg::upf_result_type r1,
   output logic [1:0]            n_res
);

   logic                           handled;
   logic                           skip;
   logic [1:0]                     phase;
   logic                           drop_lf;
   logic [8:0]                     fold;
   logic                           emit_a, emit_b, emit_c;
   logic                           bump_a, bump_b;
   logic [7:0]                     byte_a, byte_b;
   logic [upf_pkg::COUNT_BITS-1:0] cnt_a, cnt_b, cnt_c;
   upf_pkg::upf_result_type        res_a, res_b, res_c, res_m;

   assign fold = upf_pkg::fold_code(in_byte);

   always_comb begin
      handled = 1'b0;
      skip    = state_cur.skip;
      phase   = state_cur.phase;
      drop_lf = 1'b0;
      emit_a  = 1'b0;
      bump_a  = 1'b0;
      byte_a  = upf_pkg::BYTE_QMARK;
      emit_b  = 1'b0;
      bump_b  = 1'b0;
      byte_b  = in_byte;

      // Pending prefix: complete, fold or replace it.
      case (state_cur.phase)
         upf_pkg::PHASE_E2: begin
            if (in_byte == upf_pkg::BYTE_SEC_80) begin
               phase   = upf_pkg::PHASE_E2_80;
               handled = 1'b1;
            end else begin
               phase  = upf_pkg::PHASE_NONE;
               emit_a = 1'b1;
               bump_a = 1'b1;
               skip   = 1'b1;
            end
         end
         upf_pkg::PHASE_E2_80: begin
            phase  = upf_pkg::PHASE_NONE;
            emit_a = 1'b1;
            bump_a = 1'b1;
            if (fold[8]) begin
               byte_a  = fold[7:0];
               handled = 1'b1;
            end else begin
               skip = 1'b1;
            end
         end
         default: ;
      endcase

      // Drop continuation bytes after a replaced sequence.
      if (!handled && skip) begin
         if (in_byte[7:6] == 2'b10) handled = 1'b1;
         else                       skip    = 1'b0;
      end

      // LF right after CR in CRLF mode is dropped.
      if (!handled && state_cur.drop_lf && in_byte == upf_pkg::BYTE_LF) handled = 1'b1;

      // Plain byte handling.
      if (!handled) begin
         if (in_byte == upf_pkg::BYTE_CR) begin
            emit_b  = 1'b1;
            byte_b  = upf_pkg::BYTE_CR;
            drop_lf = (line_end_mode == upf_pkg::MODE_CRLF);
         end else if (in_byte == upf_pkg::BYTE_LF) begin
            emit_b = 1'b1;
            byte_b = upf_pkg::BYTE_CR;
         end else if (in_byte == upf_pkg::BYTE_LEAD_E2) begin
            phase = upf_pkg::PHASE_E2;
         end else if (in_byte >= upf_pkg::BYTE_LEAD_LO) begin
            emit_b = 1'b1;
            bump_b = 1'b1;
            byte_b = upf_pkg::BYTE_QMARK;
            skip   = 1'b1;
         end else begin
            emit_b = 1'b1;
         end
      end

      // A prefix still open at the end of the text gives one more '?'.
      emit_c = end_of_text && (phase != upf_pkg::PHASE_NONE);
   end

   // Running count after each possible emission.
   assign cnt_a = bump_a ? upf_pkg::sat_inc(state_cur.count) : state_cur.count;
   assign cnt_b = bump_b ? upf_pkg::sat_inc(cnt_a) : cnt_a;
   assign cnt_c = emit_c ? upf_pkg::sat_inc(cnt_b) : cnt_b;

   always_comb begin
      res_a = '{byte_valid: 1'b1, out_byte: byte_a, last_of_text: 1'b0,
                fold_count: upf_pkg::count_field(cnt_a)};
      res_b = '{byte_valid: 1'b1, out_byte: byte_b, last_of_text: 1'b0,
                fold_count: upf_pkg::count_field(cnt_b)};
      res_c = '{byte_valid: 1'b1, out_byte: upf_pkg::BYTE_QMARK, last_of_text: 1'b0,
                fold_count: upf_pkg::count_field(cnt_c)};
      res_m = '{byte_valid: 1'b0, out_byte: 8'd0, last_of_text: 1'b1,
                fold_count: upf_pkg::count_field(cnt_c)};

      // Pack the emitted results in order; at most two are ever present.
      n_res = 2'(emit_a) + 2'(emit_b) + 2'(emit_c);
      r0    = emit_a ? res_a : (emit_b ? res_b : res_c);
      r1    = (emit_a && emit_b) ? res_b : res_c;

      if (end_of_text) begin
         if (n_res == 2'd0) begin
            r0    = res_m;
            n_res = 2'd1;
         end else if (n_res == 2'd1) begin
            r0.last_of_text = 1'b1;
         end else begin
            r1.last_of_text = 1'b1;
         end
      end
   end

   // Next state; the end of the text clears everything.
   always_comb begin
      if (end_of_text) begin
         state_nxt = '0;
      end else begin
         state_nxt.phase   = phase;
         state_nxt.drop_lf = drop_lf;
         state_nxt.skip    = skip;
         state_nxt.count   = cnt_c;
      end
   end

endmodule

@@ rtl/core/upf_out_queue.sv @@
// Two-entry result queue that holds the results of one byte for the output.
// Depends on upf_pkg for the result and push types.
`timescale 1ns / 1ps

module upf_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  upf_pkg::upf_push_type   push_in,
   output logic                    can_take,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output upf_pkg::upf_result_type rsp_head
);

   logic [1:0]              cnt_ff, cnt_in;
   upf_pkg::upf_result_type slot0_ff, slot0_in;
   upf_pkg::upf_result_type slot1_ff, slot1_in;
   logic                    pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_head  = slot0_ff;
   assign pop       = rsp_valid && rsp_ready;
   // A new byte's results enter only when the queue is empty or drains this cycle.
   assign can_take  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push_in.push) begin
         cnt_in   = push_in.n_res;
         slot0_in = push_in.r0;
         slot1_in = push_in.r1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/core/utf8_punctuation_fold.sv @@
// Top level of the UTF-8 punctuation fold block: input register, state,
// fold logic and result queue. Depends on upf_pkg, upf_fold_logic, upf_out_queue.
`timescale 1ns / 1ps

// Usage:
// Text enters one byte per item on the req_ channel (req_in_byte, with
// req_end_of_text on the final byte). Results leave on the rsp_ channel, one
// item per result. A byte gives zero, one or two results; the final byte of a
// text always gives at least one, the last carrying rsp_last_of_text.
// csr_line_end_mode is written through the csr_ channel, which is always ready;
// write it only while the block is idle.
// Path: a byte taken is held in the input register, then its results are
// registered in the result queue, from which they are offered; the byte
// waits in the input register while the queue cannot take its results.
// Throughput: one byte per cycle while the receiver takes every result; after
// a byte with two results the next byte waits while the two-entry queue drains.
// Reset clears the input register, the queue, the fold state and the mode.
// When the receiver stalls, results stay in the queue, the input register
// fills and req_ready drops until the queue can take the next byte.

module utf8_punctuation_fold (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_text,
   output logic [23:0] rsp_fold_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_line_end_mode
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   logic                    in_eot_ff, in_eot_in;
   logic [1:0]              mode_ff, mode_in;
   upf_pkg::upf_state_type  state_ff, state_in, state_nxt;
   upf_pkg::upf_result_type r0, r1, head;
   logic [1:0]              n_res;
   logic                    can_take;
   logic                    advance;
   upf_pkg::upf_push_type   push;

   // Configuration register.
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_line_end_mode : mode_ff;

   // Input register; it moves on when the queue can take its results.
   assign advance     = in_valid_ff && can_take;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_byte_in  = (req_valid && req_ready) ? req_in_byte : in_byte_ff;
   assign in_eot_in   = (req_valid && req_ready) ? req_end_of_text : in_eot_ff;

   upf_fold_logic u_logic (
      .in_byte       (in_byte_ff),
      .end_of_text   (in_eot_ff),
      .line_end_mode (mode_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_nxt),
      .r0            (r0),
      .r1            (r1),
      .n_res         (n_res)
   );

   // State advances with the item that leaves the input register.
   assign state_in = advance ? state_nxt : state_ff;

   assign push.push  = advance;
   assign push.n_res = n_res;
   assign push.r0    = r0;
   assign push.r1    = r1;

   upf_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_head  (head)
   );

   assign rsp_byte_valid   = head.byte_valid;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_last_of_text = head.last_of_text;
   assign rsp_fold_count   = head.fold_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= upf_pkg::MODE_CR;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         state_ff    <= state_in;
      end
      in_byte_ff <= in_byte_in;
      in_eot_ff  <= in_eot_in;
   end

`ifndef ASSERT_OFF
   // The end of a text leaves the block with clean state and a zero count.
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      advance && in_eot_ff |=> state_ff == '0)
      else $error("state not cleared after end of text");

   // The final byte of a text always yields at least one result.
   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_eot_ff |-> n_res != 2'd0)
      else $error("end of text produced no result");

   // The prefix tracker never holds the unused code.
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == upf_pkg::PHASE_NONE || state_ff.phase == upf_pkg::PHASE_E2 ||
      state_ff.phase == upf_pkg::PHASE_E2_80)
      else $error("illegal prefix phase");

   // Within a text the count never goes down.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance && !in_eot_ff |=> state_ff.count >= $past(state_ff.count))
      else $error("fold count decreased within a text");
`endif

endmodule

@@ tb/utf8_punctuation_fold_tb.sv @@
// Self-checking testbench for utf8_punctuation_fold: directed table, then random texts.
// Depends on upf_pkg for the result type and byte codes, and on the block's RTL.
`timescale 1ns / 1ps

module utf8_punctuation_fold_tb;

   // Mode value outside the documented range; it must behave like CR mode.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Result item at which the receiver stops taking results for a long stretch.
   localparam int HOLD_AT_RESULT = 600;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_BYTES    = 250;
   localparam int PHASE_COUNT    = 5;

   typedef struct {
      logic [7:0]              in_byte;
      logic                    eot;
      logic                    typed;
      upf_pkg::upf_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_text;
   logic [23:0] rsp_fold_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_line_end_mode;

   // Predictor state: mirror of the block's text state and its mode register.
   logic [1:0]                     line_mode;
   logic [1:0]                     text_phase;
   logic                           text_drop_lf;
   logic                           text_skip;
   logic [upf_pkg::COUNT_BITS-1:0] fold_total;

   upf_pkg::upf_result_type expected_out [$];
   stim_row_type            directed_rows [$];

   logic no_idle;
   int   mismatch_total;
   int   results_checked;
   int   results_taken;
   int   bytes_sent;
   int   texts_sent;

   utf8_punctuation_fold uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_text  (rsp_last_of_text),
      .rsp_fold_count    (rsp_fold_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_line_end_mode (csr_line_end_mode)
   );

   always #10 clock = ~clock;

   // A result item carrying the current fold count.
   function automatic upf_pkg::upf_result_type out_item(input logic v, input logic [7:0] ob);
      upf_pkg::upf_result_type res;
      res.byte_valid   = v;
      res.out_byte     = ob;
      res.last_of_text = 1'b0;
      res.fold_count   = fold_total[upf_pkg::FIELD_BITS-1:0];
      return res;
   endfunction

   // Saturating step of the fold counter.
   task automatic bump_folds();
      if (fold_total != {upf_pkg::COUNT_BITS{1'b1}})
         fold_total = fold_total + {{(upf_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
   endtask

   // Works out the result items of one text byte and queues them.
   task automatic fold_byte(input logic [7:0] b, input logic eot);
      upf_pkg::upf_result_type res [3];
      int n;
      int i;
      logic after_cr;
      logic done;
      logic [7:0] code;
      n = 0;
      after_cr = text_drop_lf;
      done = 1'b0;
      code = 8'h00;
      text_drop_lf = 1'b0;

      // Finish or break a pending E2 / E2 80 prefix.
      if (text_phase == upf_pkg::PHASE_E2) begin
         if (b == upf_pkg::BYTE_SEC_80) begin
            text_phase = upf_pkg::PHASE_E2_80;
            done = 1'b1;
         end else begin
            text_phase = upf_pkg::PHASE_NONE;
            bump_folds();
            res[n] = out_item(1'b1, upf_pkg::BYTE_QMARK);
            n++;
            text_skip = 1'b1;
         end
      end else if (text_phase == upf_pkg::PHASE_E2_80) begin
         text_phase = upf_pkg::PHASE_NONE;
         case (b)
            8'h98:   code = 8'hD4;
            8'h99:   code = 8'hD5;
            8'h9C:   code = 8'hD2;
            8'h9D:   code = 8'hD3;
            8'h93:   code = 8'hD0;
            8'h94:   code = 8'hD1;
            8'hA6:   code = 8'hC9;
            default: code = 8'h00;
         endcase
         bump_folds();
         if (code != 8'h00) begin
            res[n] = out_item(1'b1, code);
            done = 1'b1;
         end else begin
            res[n] = out_item(1'b1, upf_pkg::BYTE_QMARK);
            text_skip = 1'b1;
         end
         n++;
      end

      // Continuation bytes after a replaced sequence are swallowed.
      if (!done && text_skip) begin
         if (b[7:6] == 2'b10)
            done = 1'b1;
         else
            text_skip = 1'b0;
      end

      if (!done && after_cr && b == upf_pkg::BYTE_LF)
         done = 1'b1;

      // Plain byte handling.
      if (!done) begin
         if (b == upf_pkg::BYTE_CR) begin
            res[n] = out_item(1'b1, upf_pkg::BYTE_CR);
            n++;
            text_drop_lf = (line_mode == upf_pkg::MODE_CRLF);
         end else if (b == upf_pkg::BYTE_LF) begin
            res[n] = out_item(1'b1, upf_pkg::BYTE_CR);
            n++;
         end else if (b == upf_pkg::BYTE_LEAD_E2) begin
            text_phase = upf_pkg::PHASE_E2;
         end else if (b >= upf_pkg::BYTE_LEAD_LO) begin
            bump_folds();
            res[n] = out_item(1'b1, upf_pkg::BYTE_QMARK);
            n++;
            text_skip = 1'b1;
         end else begin
            res[n] = out_item(1'b1, b);
            n++;
         end
      end

      // End of text: flush a pending prefix, mark the last item, clear state.
      if (eot) begin
         if (text_phase != upf_pkg::PHASE_NONE) begin
            bump_folds();
            res[n] = out_item(1'b1, upf_pkg::BYTE_QMARK);
            n++;
         end
         if (n == 0) begin
            res[n] = out_item(1'b0, 8'h00);
            n++;
         end
         res[n-1].last_of_text = 1'b1;
         text_phase = upf_pkg::PHASE_NONE;
         text_drop_lf = 1'b0;
         text_skip = 1'b0;
         fold_total = '0;
      end

      for (i = 0; i < n; i++)
         expected_out.push_back(res[i]);
   endtask

   // Offers one byte after a random gap and returns at the edge that takes it.
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (eot)
         texts_sent++;
   endtask

   // Sends one random token of text: mostly well-formed sequences, some noise.
   task automatic send_token();
      logic [7:0] seq [$];
      logic       eot;
      int         kind;
      int         i;
      int         extra;
      kind = $urandom_range(0, 99);
      extra = 0;
      if (kind < 30) begin
         seq.push_back(upf_pkg::BYTE_LEAD_E2);
         seq.push_back(upf_pkg::BYTE_SEC_80);
         case ($urandom_range(0, 6))
            0:       seq.push_back(8'h98);
            1:       seq.push_back(8'h99);
            2:       seq.push_back(8'h9C);
            3:       seq.push_back(8'h9D);
            4:       seq.push_back(8'h93);
            5:       seq.push_back(8'h94);
            default: seq.push_back(8'hA6);
         endcase
      end else if (kind < 45) begin
         seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 52) begin
         seq.push_back(upf_pkg::BYTE_CR);
      end else if (kind < 58) begin
         seq.push_back(upf_pkg::BYTE_LF);
      end else if (kind < 64) begin
         seq.push_back(upf_pkg::BYTE_CR);
         seq.push_back(upf_pkg::BYTE_LF);
      end else if (kind < 70) begin
         seq.push_back(upf_pkg::BYTE_LEAD_E2);
         seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
         seq.push_back(upf_pkg::BYTE_LEAD_E2);
         seq.push_back(upf_pkg::BYTE_SEC_80);
         seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
         seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         extra = $urandom_range(0, 3);
         for (i = 0; i < extra; i++)
            seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 87) begin
         seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 90) begin
         seq.push_back(upf_pkg::BYTE_LEAD_E2);
      end else if (kind < 92) begin
         seq.push_back(upf_pkg::BYTE_LEAD_E2);
         seq.push_back(upf_pkg::BYTE_SEC_80);
      end else begin
         seq.push_back(8'($urandom_range(0, 255)));
      end

      eot = ($urandom_range(0, 24) == 0);
      for (i = 0; i < seq.size(); i++) begin
         send_byte(seq[i], eot && (i == seq.size() - 1));
         fold_byte(seq[i], eot && (i == seq.size() - 1));
      end
   endtask

   // Writes the line end mode; the block must be idle.
   task automatic write_mode(input logic [1:0] m);
      csr_valid <= 1'b1;
      csr_line_end_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      line_mode = m;
   endtask

   // Stops offering and waits until every expected result item has arrived,
   // then waits on for a byte still in flight that gives no result.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic add_row(input logic [7:0] b, input logic eot, input logic typed,
                          input logic bv, input logic [7:0] ob, input logic last,
                          input logic [23:0] cnt);
      stim_row_type row;
      row.in_byte = b;
      row.eot = eot;
      row.typed = typed;
      row.want.byte_valid = bv;
      row.want.out_byte = ob;
      row.want.last_of_text = last;
      row.want.fold_count = cnt;
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_total++;
      end
   endtask

   // Result checker: every accepted item against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      upf_pkg::upf_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            $error("result item with no expectation: out_byte %0h", rsp_out_byte);
            mismatch_total++;
         end else begin
            want = expected_out.pop_front();
            check_field("byte_valid", 32'(want.byte_valid), 32'(rsp_byte_valid));
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
            check_field("last_of_text", 32'(want.last_of_text), 32'(rsp_last_of_text));
            check_field("fold_count", 32'(want.fold_count), 32'(rsp_fold_count));
            results_checked++;
         end
      end
   end

   // Receiver: random stalls per item, one long hold-off to back up the block.
   initial begin : rsp_sink
      int gap;
      rsp_ready = 1'b0;
      results_taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 10);
         if (results_taken == HOLD_AT_RESULT)
            gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
      end
   end

   // Run limit, far above the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // Main sequence: reset, directed table, random phases over all modes.
   initial begin : stimulus
      logic [1:0] phase_modes [PHASE_COUNT];
      int phase_idx;
      int row_idx;
      int queued;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_end_of_text = 1'b0;
      csr_valid = 1'b0;
      csr_line_end_mode = upf_pkg::MODE_CR;
      no_idle = 1'b0;
      mismatch_total = 0;
      results_checked = 0;
      bytes_sent = 0;
      texts_sent = 0;
      line_mode = upf_pkg::MODE_CR;
      text_phase = upf_pkg::PHASE_NONE;
      text_drop_lf = 1'b0;
      text_skip = 1'b0;
      fold_total = '0;
      phase_modes[0] = upf_pkg::MODE_CR;
      phase_modes[1] = upf_pkg::MODE_LF;
      phase_modes[2] = MODE_UNUSED;
      phase_modes[3] = upf_pkg::MODE_CRLF;
      phase_modes[4] = upf_pkg::MODE_CR;

      // Directed table in CRLF mode; typed rows give their single result.
      add_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 24'd0);
      add_row(8'h7F, 1'b0, 1'b1, 1'b1, 8'h7F, 1'b0, 24'd0);
      add_row(8'hBF, 1'b0, 1'b1, 1'b1, 8'hBF, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_CR, 1'b0, 1'b1, 1'b1, upf_pkg::BYTE_CR, 1'b0, 24'd0);
      // An LF right after CR is dropped; the next lone LF becomes CR.
      add_row(upf_pkg::BYTE_LF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_LF, 1'b0, 1'b1, 1'b1, upf_pkg::BYTE_CR, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_SEC_80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'h98, 1'b0, 1'b1, 1'b1, 8'hD4, 1'b0, 24'd1);
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_SEC_80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'hA6, 1'b0, 1'b1, 1'b1, 8'hC9, 1'b0, 24'd2);
      // Broken prefix after E2: a replacement, then the byte itself.
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'h41, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      // Broken prefix after E2 80 with a continuation byte, which is dropped.
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_SEC_80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'h85, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'h90, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      // Other lead byte: replaced, its continuation dropped.
      add_row(8'hC3, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'hA9, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(8'h41, 1'b0, 1'b1, 1'b1, 8'h41, 1'b0, 24'd5);
      // Pending prefix at end of text.
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b1, 1'b1, 1'b1, upf_pkg::BYTE_QMARK, 1'b1, 24'd6);
      // Nothing emitted at end: the end-only marker.
      add_row(upf_pkg::BYTE_CR, 1'b0, 1'b1, 1'b1, upf_pkg::BYTE_CR, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_LF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 24'd0);
      add_row(8'hFF, 1'b1, 1'b1, 1'b1, upf_pkg::BYTE_QMARK, 1'b1, 24'd1);
      add_row(upf_pkg::BYTE_LEAD_E2, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 24'd0);
      add_row(upf_pkg::BYTE_SEC_80, 1'b1, 1'b1, 1'b1, upf_pkg::BYTE_QMARK, 1'b1, 24'd1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_mode(upf_pkg::MODE_CRLF);
      for (row_idx = 0; row_idx < directed_rows.size(); row_idx++) begin
         send_byte(directed_rows[row_idx].in_byte, directed_rows[row_idx].eot);
         queued = expected_out.size();
         fold_byte(directed_rows[row_idx].in_byte, directed_rows[row_idx].eot);
         if (directed_rows[row_idx].typed) begin
            while (expected_out.size() > queued)
               void'(expected_out.pop_back());
            expected_out.push_back(directed_rows[row_idx].want);
         end
      end
      drain();

      // Random phases, one per mode setting; one phase runs without idling.
      for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         write_mode(phase_modes[phase_idx]);
         no_idle = (phase_idx == 3);
         queued = bytes_sent + PHASE_BYTES;
         while (bytes_sent < queued)
            send_token();
         drain();
         no_idle = 1'b0;
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d texts across line end modes CR, LF, CRLF and unused.",
               bytes_sent, texts_sent);
      $display("Checked %0d result items, %0d mismatches.", results_checked, mismatch_total);
      if (mismatch_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
